>>> hw/rtl/erv_pkg.sv
// ============================================================================
// Event record stream validator package
// Shared phase and tag codes, control structs, constants and magic bytes of the validator.
// ============================================================================
package erv_pkg;

   localparam int unsigned DefMaxNest  = 8;
   localparam int unsigned DefMaxProps = 64;

   localparam int unsigned VarintMaxBytes = 10;

   typedef enum logic [4:0] {
      PH_MAGIC, PH_STAMP, PH_DIST_LEN, PH_DIST_BODY, PH_FLAG, PH_SESS_LEN,
      PH_SESS_BODY, PH_EVT_LEN, PH_EVT_BODY, PH_PCOUNT, PH_KEY_LEN, PH_KEY_BODY,
      PH_TAG, PH_NUM, PH_FIXED, PH_BLOB_LEN, PH_BLOB_BODY, PH_VSTR_LEN,
      PH_VSTR_BODY, PH_ARR_COUNT, PH_MAP_COUNT, PH_DONE
   } phase_type;

   typedef enum logic [7:0] {
      TAG_NULL   = 8'd0,
      TAG_FALSE  = 8'd1,
      TAG_TRUE   = 8'd2,
      TAG_UINT   = 8'd3,
      TAG_INT    = 8'd4,
      TAG_F32    = 8'd5,
      TAG_F64    = 8'd6,
      TAG_STRING = 8'd7,
      TAG_BYTES  = 8'd8,
      TAG_ARRAY  = 8'd9,
      TAG_MAP    = 8'd10
   } tag_type;

   // Container stack commands from the parser.
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
      logic is_map;
   } stk_cmd_type;

   // Container stack status toward the parser.
   typedef struct packed {
      logic found;    // some open level survives the pop
      logic top_map;  // that surviving level is a map
      logic full;
   } stk_stat_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0:    b = 8'h48;
         2'd1:    b = 8'h51;
         2'd2:    b = 8'h52;
         default: b = 8'h31;
      endcase
      return b;
   endfunction

endpackage

>>> hw/rtl/erv_utf8.sv
// ============================================================================
// UTF-8 byte checker
// Checks one string byte against the pending UTF-8 sequence state.
// ============================================================================
module erv_utf8 (
   input  logic [4:0] pending,
   input  logic [7:0] data,
   output logic       ok,
   output logic [4:0] pending_next
);

   logic [1:0] need;
   logic [2:0] rule;
   logic [7:0] lo;
   logic [7:0] hi;

   assign need = pending[1:0];
   assign rule = pending[4:2];

   always_comb begin
      lo = 8'h80;
      hi = 8'hBF;
      case (rule)
         3'd1:    lo = 8'hA0;
         3'd2:    hi = 8'h9F;
         3'd3:    lo = 8'h90;
         3'd4:    hi = 8'h8F;
         default: ;
      endcase
      ok = 1'b0;
      pending_next = pending;
      if (need != 2'd0) begin
         ok = (data >= lo) && (data <= hi);
         pending_next = {3'd0, need - 2'd1};
      end else if (data < 8'h80) begin
         ok = 1'b1;
      end else if (data >= 8'hC2 && data <= 8'hDF) begin
         ok = 1'b1;
         pending_next = 5'd1;
      end else if (data == 8'hE0) begin
         ok = 1'b1;
         pending_next = {3'd1, 2'd2};
      end else if (data == 8'hED) begin
         ok = 1'b1;
         pending_next = {3'd2, 2'd2};
      end else if (data >= 8'hE1 && data <= 8'hEF) begin
         ok = 1'b1;
         pending_next = 5'd2;
      end else if (data == 8'hF0) begin
         ok = 1'b1;
         pending_next = {3'd3, 2'd3};
      end else if (data == 8'hF4) begin
         ok = 1'b1;
         pending_next = {3'd4, 2'd3};
      end else if (data >= 8'hF1 && data <= 8'hF3) begin
         ok = 1'b1;
         pending_next = 5'd3;
      end
   end

endmodule

>>> hw/rtl/erv_stack.sv
// ============================================================================
// Container stack
// Per-level element counts of open arrays and maps; a pop unwinds all finished levels at once.
// ============================================================================
module erv_stack #(
   parameter int unsigned MAX_NEST = erv_pkg::DefMaxNest
) (
   input  logic                 clock,
   input  logic                 reset,
   input  erv_pkg::stk_cmd_type cmd,
   input  logic [63:0]          count,
   output erv_pkg::stk_stat_type stat
);

   localparam int unsigned DepthW = $clog2(MAX_NEST + 1);
   localparam int unsigned IdxW   = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

   logic [63:0]       rem_ff [MAX_NEST];
   logic              map_ff [MAX_NEST];
   logic [DepthW-1:0] depth_ff;
   logic [DepthW-1:0] depth_in;
   logic [IdxW-1:0]   sel;
   logic              found;

   // The innermost open level whose count is not about to reach zero keeps
   // the value; every level above it closes along with the finished value.
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int i = 0; i < MAX_NEST; i++) begin
         if (DepthW'(i) < depth_ff && rem_ff[i] != 64'd1) begin
            found = 1'b1;
            sel   = IdxW'(i);
         end
      end
   end

   assign stat.found   = found;
   assign stat.top_map = map_ff[sel];
   assign stat.full    = depth_ff >= DepthW'(MAX_NEST);

   always_comb begin
      depth_in = depth_ff;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in = depth_ff + DepthW'(1);
      end else if (cmd.pop) begin
         depth_in = found ? DepthW'(sel) + DepthW'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_NEST; i++) begin
         if (!cmd.clear && cmd.push && depth_ff == DepthW'(i)) begin
            rem_ff[i] <= count;
            map_ff[i] <= cmd.is_map;
         end else if (!cmd.clear && cmd.pop && found && sel == IdxW'(i)) begin
            rem_ff[i] <= rem_ff[i] - 64'd1;
         end
      end
   end

endmodule

>>> hw/rtl/event_record_stream_validator.sv
// ============================================================================
// Event record stream validator
// Checks a serialized event record byte by byte and reports its validity.
// ============================================================================
//
// Channel  Direction  Ports                                   Transfer
// req      in         req_data_byte, req_last_byte            one record byte
// rsp      out        rsp_record_ok, rsp_property_total       one per record
//
// A new byte may be taken every cycle while req_ready is high. The whole
// per-byte update (LEB128 gather, UTF-8 check, container unwinding) sits
// between the state registers and the result register.
// A result is offered in the cycle after the last byte is taken.
// req_ready drops only while a finished result waits with rsp_ready low.
// Reset is synchronous and active high; it returns the parser to the magic.
//
module event_record_stream_validator #(
   parameter int unsigned MAX_NEST  = erv_pkg::DefMaxNest,
   parameter int unsigned MAX_PROPS = erv_pkg::DefMaxProps
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_record_ok,
   output logic [6:0] rsp_property_total
);

   // Parser state.
   erv_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  magic_pos_ff, magic_pos_in;
   logic [63:0] vval_ff, vval_in;
   logic [3:0]  vseen_ff, vseen_in;
   logic [63:0] rem_ff, rem_in;
   logic        is_key_ff, is_key_in;
   logic [4:0]  utf_ff, utf_in;
   logic [6:0]  left_ff, left_in;
   logic [6:0]  done_ff, done_in;
   logic        stamp_ff, stamp_in;
   logic        err_ff, err_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic        out_ok_ff, out_ok_in;
   logic [6:0]  out_total_ff, out_total_in;

   logic        accept;
   logic        vd;          // the current value has finished
   logic        push;
   logic        push_map;
   logic [63:0] push_count;
   logic [63:0] vnew;
   logic [6:0]  shamt;
   logic        utf_ok;
   logic [4:0]  utf_next;

   erv_pkg::stk_cmd_type  stk_cmd;
   erv_pkg::stk_stat_type stk_stat;

   // The input side stalls only while a result still waits downstream.
   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign rsp_valid          = out_valid_ff;
   assign rsp_record_ok      = out_ok_ff;
   assign rsp_property_total = out_total_ff;

   erv_utf8 u_utf8 (
      .pending      (utf_ff),
      .data         (req_data_byte),
      .ok           (utf_ok),
      .pending_next (utf_next)
   );

   // A LEB128 byte lands seven bits further up for every byte already seen;
   // bits shifted past bit 63 are simply lost.
   assign shamt = {vseen_ff, 3'b000} - {3'b000, vseen_ff};
   assign vnew  = vval_ff | ({57'd0, req_data_byte[6:0]} << shamt);

   always_comb begin
      phase_in     = phase_ff;
      magic_pos_in = magic_pos_ff;
      vval_in      = vval_ff;
      vseen_in     = vseen_ff;
      rem_in       = rem_ff;
      is_key_in    = is_key_ff;
      utf_in       = utf_ff;
      left_in      = left_ff;
      done_in      = done_ff;
      stamp_in     = stamp_ff;
      err_in       = err_ff;
      vd           = 1'b0;
      push         = 1'b0;
      push_map     = 1'b0;
      push_count   = vnew;

      if (accept && !err_ff) begin
         case (phase_ff)
            erv_pkg::PH_MAGIC: begin
               if (req_data_byte != erv_pkg::magic_byte(magic_pos_ff)) begin
                  err_in = 1'b1;
               end else if (magic_pos_ff == 2'd3) begin
                  magic_pos_in = 2'd0;
                  phase_in     = erv_pkg::PH_STAMP;
               end else begin
                  magic_pos_in = magic_pos_ff + 2'd1;
               end
            end
            erv_pkg::PH_DIST_BODY, erv_pkg::PH_SESS_BODY, erv_pkg::PH_EVT_BODY,
            erv_pkg::PH_KEY_BODY, erv_pkg::PH_VSTR_BODY: begin
               if (rem_ff == 64'd0) begin
                  // The terminator: it must be NUL with no sequence left open.
                  if (req_data_byte != 8'd0 || utf_ff != 5'd0) begin
                     err_in = 1'b1;
                  end else begin
                     case (phase_ff)
                        erv_pkg::PH_DIST_BODY: phase_in = erv_pkg::PH_FLAG;
                        erv_pkg::PH_SESS_BODY: phase_in = erv_pkg::PH_EVT_LEN;
                        erv_pkg::PH_EVT_BODY:  phase_in = erv_pkg::PH_PCOUNT;
                        erv_pkg::PH_KEY_BODY:  phase_in = erv_pkg::PH_TAG;
                        default:               vd = 1'b1;
                     endcase
                  end
               end else if ((is_key_ff && req_data_byte == 8'd0) || !utf_ok) begin
                  err_in = 1'b1;
               end else begin
                  utf_in = utf_next;
                  rem_in = rem_ff - 64'd1;
               end
            end
            erv_pkg::PH_FLAG: begin
               if (req_data_byte > 8'd1) begin
                  err_in = 1'b1;
               end else begin
                  phase_in = req_data_byte[0] ? erv_pkg::PH_SESS_LEN
                                              : erv_pkg::PH_EVT_LEN;
               end
            end
            erv_pkg::PH_TAG: begin
               case (req_data_byte)
                  erv_pkg::TAG_NULL, erv_pkg::TAG_FALSE, erv_pkg::TAG_TRUE:
                     vd = 1'b1;
                  erv_pkg::TAG_UINT, erv_pkg::TAG_INT:
                     phase_in = erv_pkg::PH_NUM;
                  erv_pkg::TAG_F32: begin
                     rem_in   = 64'd4;
                     phase_in = erv_pkg::PH_FIXED;
                  end
                  erv_pkg::TAG_F64: begin
                     rem_in   = 64'd8;
                     phase_in = erv_pkg::PH_FIXED;
                  end
                  erv_pkg::TAG_STRING:
                     phase_in = erv_pkg::PH_VSTR_LEN;
                  erv_pkg::TAG_BYTES:
                     phase_in = erv_pkg::PH_BLOB_LEN;
                  erv_pkg::TAG_ARRAY, erv_pkg::TAG_MAP: begin
                     if (stk_stat.full) begin
                        err_in = 1'b1;
                     end else begin
                        phase_in = (req_data_byte == erv_pkg::TAG_ARRAY)
                                   ? erv_pkg::PH_ARR_COUNT : erv_pkg::PH_MAP_COUNT;
                     end
                  end
                  default: err_in = 1'b1;
               endcase
            end
            erv_pkg::PH_FIXED, erv_pkg::PH_BLOB_BODY: begin
               rem_in = rem_ff - 64'd1;
               if (rem_ff == 64'd1) begin
                  vd = 1'b1;
               end
            end
            erv_pkg::PH_DONE: begin
               // Anything after the last property is a trailing byte.
               err_in = 1'b1;
            end
            default: begin
               // Every remaining phase gathers a LEB128 value.
               if (vseen_ff >= 4'(erv_pkg::VarintMaxBytes)) begin
                  err_in = 1'b1;
               end else if (req_data_byte[7]) begin
                  if (vseen_ff + 4'd1 >= 4'(erv_pkg::VarintMaxBytes)) begin
                     err_in = 1'b1;
                  end else begin
                     vval_in  = vnew;
                     vseen_in = vseen_ff + 4'd1;
                  end
               end else begin
                  vval_in  = 64'd0;
                  vseen_in = 4'd0;
                  case (phase_ff)
                     erv_pkg::PH_STAMP: begin
                        stamp_in = vnew != 64'd0;
                        phase_in = erv_pkg::PH_DIST_LEN;
                     end
                     erv_pkg::PH_DIST_LEN, erv_pkg::PH_SESS_LEN,
                     erv_pkg::PH_EVT_LEN, erv_pkg::PH_KEY_LEN,
                     erv_pkg::PH_VSTR_LEN: begin
                        is_key_in = phase_ff != erv_pkg::PH_VSTR_LEN;
                        if (phase_ff != erv_pkg::PH_VSTR_LEN && vnew == 64'd0) begin
                           err_in = 1'b1;
                        end else begin
                           rem_in = vnew;
                           utf_in = 5'd0;
                           case (phase_ff)
                              erv_pkg::PH_DIST_LEN: phase_in = erv_pkg::PH_DIST_BODY;
                              erv_pkg::PH_SESS_LEN: phase_in = erv_pkg::PH_SESS_BODY;
                              erv_pkg::PH_EVT_LEN:  phase_in = erv_pkg::PH_EVT_BODY;
                              erv_pkg::PH_KEY_LEN:  phase_in = erv_pkg::PH_KEY_BODY;
                              default:              phase_in = erv_pkg::PH_VSTR_BODY;
                           endcase
                        end
                     end
                     erv_pkg::PH_PCOUNT: begin
                        if (vnew > 64'(MAX_PROPS)) begin
                           err_in = 1'b1;
                        end else begin
                           left_in  = vnew[6:0];
                           phase_in = (vnew == 64'd0) ? erv_pkg::PH_DONE
                                                      : erv_pkg::PH_KEY_LEN;
                        end
                     end
                     erv_pkg::PH_NUM: vd = 1'b1;
                     erv_pkg::PH_BLOB_LEN: begin
                        if (vnew == 64'd0) begin
                           vd = 1'b1;
                        end else begin
                           rem_in   = vnew;
                           phase_in = erv_pkg::PH_BLOB_BODY;
                        end
                     end
                     erv_pkg::PH_ARR_COUNT, erv_pkg::PH_MAP_COUNT: begin
                        if (vnew == 64'd0) begin
                           vd = 1'b1;
                        end else if (stk_stat.full) begin
                           err_in = 1'b1;
                        end else begin
                           push     = 1'b1;
                           push_map = phase_ff == erv_pkg::PH_MAP_COUNT;
                           phase_in = push_map ? erv_pkg::PH_KEY_LEN : erv_pkg::PH_TAG;
                        end
                     end
                     default: err_in = 1'b1;
                  endcase
               end
            end
         endcase

         // A finished value either stays inside a surviving container or
         // completes a top-level property.
         if (vd) begin
            if (stk_stat.found) begin
               phase_in = stk_stat.top_map ? erv_pkg::PH_KEY_LEN : erv_pkg::PH_TAG;
            end else begin
               done_in  = done_ff + 7'd1;
               left_in  = left_ff - 7'd1;
               phase_in = (left_ff == 7'd1) ? erv_pkg::PH_DONE : erv_pkg::PH_KEY_LEN;
            end
         end
      end

      // Result of the record, then a fresh start for the next one.
      out_valid_in = out_valid_ff && !rsp_ready;
      out_ok_in    = out_ok_ff;
      out_total_in = out_total_ff;
      if (accept && req_last_byte) begin
         out_valid_in = 1'b1;
         out_ok_in    = !err_in && phase_in == erv_pkg::PH_DONE && stamp_in;
         out_total_in = done_in;
         phase_in     = erv_pkg::PH_MAGIC;
         magic_pos_in = 2'd0;
         vval_in      = 64'd0;
         vseen_in     = 4'd0;
         rem_in       = 64'd0;
         is_key_in    = 1'b0;
         utf_in       = 5'd0;
         left_in      = 7'd0;
         done_in      = 7'd0;
         stamp_in     = 1'b0;
         err_in       = 1'b0;
      end
   end

   assign stk_cmd.clear  = accept && req_last_byte;
   assign stk_cmd.push   = push;
   assign stk_cmd.pop    = vd;
   assign stk_cmd.is_map = push_map;

   erv_stack #(
      .MAX_NEST (MAX_NEST)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .count (push_count),
      .stat  (stk_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= erv_pkg::PH_MAGIC;
         magic_pos_ff <= 2'd0;
         vval_ff      <= 64'd0;
         vseen_ff     <= 4'd0;
         rem_ff       <= 64'd0;
         is_key_ff    <= 1'b0;
         utf_ff       <= 5'd0;
         left_ff      <= 7'd0;
         done_ff      <= 7'd0;
         stamp_ff     <= 1'b0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         magic_pos_ff <= magic_pos_in;
         vval_ff      <= vval_in;
         vseen_ff     <= vseen_in;
         rem_ff       <= rem_in;
         is_key_ff    <= is_key_in;
         utf_ff       <= utf_in;
         left_ff      <= left_in;
         done_ff      <= done_in;
         stamp_ff     <= stamp_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ok_ff    <= out_ok_in;
      out_total_ff <= out_total_in;
   end

endmodule

>>> hw/rtl/erv_checker.sv
// ============================================================================
// Validator port checker
// Port-level checks on the validator's transfers, bound to the top level.
// ============================================================================
module erv_checker #(
   parameter int unsigned MAX_PROPS = erv_pkg::DefMaxProps
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_record_ok,
   input logic [6:0] rsp_property_total
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_record_ok)
                                  && $stable(rsp_property_total))
      else $error("result changed while stalled");

   // The last byte of a record yields a result in the next cycle.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid)
      else $error("no result after last byte");

   // No result appears without a last byte.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready && req_last_byte) |=> !rsp_valid)
      else $error("result without last byte");

   // The input stalls only behind a waiting result.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without cause");

   // The reported count never exceeds the property limit.
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_property_total <= 7'(MAX_PROPS))
      else $error("property total out of range");

endmodule

bind event_record_stream_validator erv_checker #(
   .MAX_PROPS (MAX_PROPS)
) u_erv_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_last_byte      (req_last_byte),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_record_ok      (rsp_record_ok),
   .rsp_property_total (rsp_property_total)
);
